### rtl/core/cptq_pkg.sv
`timescale 1ns / 1ps
// cptq_pkg: shared types, codes and constants for the credit priority task queue
// used by cptq_ctrl, cptq_dp and credit_priority_task_queue; no dependencies
package cptq_pkg;

   // request mode codes
   localparam logic [2:0] MODE_ADD       = 3'd0;
   localparam logic [2:0] MODE_GET_NEXT  = 3'd1;
   localparam logic [2:0] MODE_GET_KEY   = 3'd2;
   localparam logic [2:0] MODE_FINISH    = 3'd3;
   localparam logic [2:0] MODE_EVENT_RDY = 3'd4;
   localparam logic [2:0] MODE_KEY_RDY   = 3'd5;

   // result status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_FULL    = 2'd1;
   localparam logic [1:0] STAT_REFUSED = 2'd2;
   localparam logic [1:0] STAT_NONE    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_SCHED     = 2'd0;
   localparam logic [1:0] CSR_CREDIT    = 2'd1;
   localparam logic [1:0] CSR_KEY_GATE  = 2'd2;

   localparam logic [35:0] CREDIT_RESET = 36'h8_0000_0000;
   localparam logic [35:0] CREDIT_MAX   = 36'hF_FFFF_FFFF;

   typedef struct packed {
      logic [2:0]         mode;
      logic [9:0]         item_key;
      logic signed [15:0] item_priority;
      logic [31:0]        item_len;
      logic               item_event_ready;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [9:0]         out_key;
      logic signed [15:0] out_priority;
      logic [31:0]        out_len;
      logic [6:0]         pending_count;
      logic [35:0]        credits_left;
   } rsp_type;

   // one stored task
   typedef struct packed {
      logic [9:0]         key;
      logic signed [15:0] prio;
      logic [31:0]        len;
      logic               ev;
   } entry_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic        sched;
      logic        gate;
      logic        credit_load;
      logic [35:0] credit_val;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       append;
      logic       sort_pass;
      logic       scan_reset;
      logic       scan_load;
      logic       scan_next;
      logic       remove;
      logic       clear_mark;
      logic       charge;
      logic       refund;
      logic       set_event;
      logic       set_mark;
      logic       clear_step;
      logic       respond;
      logic       removed;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic sort_last;
      logic scan_last;
      logic hit;
      logic evt_any;
      logic clear_last;
   } stat_type;

   // true when entry a must come after entry b
   function automatic logic goes_after(entry_type a, entry_type b);
      logic r;
      if (a.prio != b.prio) r = (a.prio < b.prio);
      else r = (a.key > b.key);
      return r;
   endfunction

endpackage

### rtl/core/cptq_ctrl.sv
`timescale 1ns / 1ps
// cptq_ctrl: sequencer for the task queue (clear, execute, sort, scan)
// depends on cptq_pkg
module cptq_ctrl
   import cptq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [2:0] req_mode,
   input  logic       sched,
   input  logic       gate,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_EXEC    = 3'd2;
   localparam logic [2:0] S_SORT    = 3'd3;
   localparam logic [2:0] S_SCAN_RD = 3'd4;
   localparam logic [2:0] S_SCAN_EV = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         mode_ff  <= MODE_ADD;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               mode_in   = req_mode;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (mode_ff)
               MODE_ADD: begin
                  if (stat.full) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     if (sched) state_in = S_SORT;
                     else cmd.respond = 1'b1;
                  end
               end
               MODE_GET_NEXT, MODE_GET_KEY: begin
                  if (mode_ff == MODE_GET_KEY && sched) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_REFUSED;
                  end else if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STAT_NONE;
                  end else begin
                     cmd.scan_reset = 1'b1;
                     state_in       = S_SCAN_RD;
                  end
               end
               MODE_FINISH: begin
                  cmd.refund  = sched;
                  cmd.respond = 1'b1;
               end
               MODE_EVENT_RDY: begin
                  cmd.set_event = 1'b1;
                  cmd.respond   = 1'b1;
                  cmd.status    = stat.evt_any ? STAT_OK : STAT_NONE;
               end
               MODE_KEY_RDY: begin
                  cmd.set_mark = 1'b1;
                  cmd.respond  = 1'b1;
               end
               default: cmd.respond = 1'b1;
            endcase
         end
         S_SORT: begin
            cmd.sort_pass = 1'b1;
            if (stat.sort_last) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_load = 1'b1;
            state_in      = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            if (stat.hit) begin
               cmd.remove     = 1'b1;
               cmd.removed    = 1'b1;
               cmd.respond    = 1'b1;
               cmd.clear_mark = (mode_ff == MODE_GET_NEXT) && gate;
               cmd.charge     = (mode_ff == MODE_GET_NEXT) && sched;
               state_in       = S_IDLE;
            end else if (stat.scan_last) begin
               cmd.respond = 1'b1;
               cmd.status  = STAT_NONE;
               state_in    = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### rtl/core/cptq_dp.sv
`timescale 1ns / 1ps
// cptq_dp: task store cells, key ready memory, credit counter and result register
// depends on cptq_pkg
module cptq_dp
   import cptq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int KEY_SPACE   = 1024
) (
   input  logic     clock,
   input  logic     reset,
   input  cmd_type  cmd,
   input  cfg_type  cfg,
   input  req_type  req_payload,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_payload
);

   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int KW = $clog2(KEY_SPACE);

   entry_type cell_ff [QUEUE_DEPTH];
   entry_type cell_in [QUEUE_DEPTH];
   entry_type up_cell [QUEUE_DEPTH];
   entry_type dn_cell [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] sw;
   logic [QUEUE_DEPTH-1:0] dn_sw;
   logic [QUEUE_DEPTH-1:0] match;

   req_type        req_ff;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pass_ff;
   logic [QW-1:0]  scan_ff;
   entry_type      scan_q_ff;
   logic           mark_ff;
   logic           inrange_ff;
   logic [35:0]    credit_ff, credit_in;
   logic [KW-1:0]  clr_ff;
   rsp_type        rsp_ff;
   logic           rsp_valid_ff;

   logic           mark_mem [KEY_SPACE];
   logic           mem_we;
   logic [KW-1:0]  mem_waddr;
   logic           mem_wdata;
   logic [31:0]    req_key_ext, cell_key_ext, q_key_ext;
   logic           req_inrange, cell_inrange;
   entry_type      scan_cell;
   logic [36:0]    refund_sum;
   logic [31:0]    count_ext;

   // store cells: append, sort pass, remove shift, event mark
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      if (k < QUEUE_DEPTH - 1) begin : g_up
         assign up_cell[k] = cell_ff[k+1];
         assign sw[k] = (CW'(k) % CW'(2) == pass_ff % CW'(2)) && (CW'(k + 1) < count_ff)
                        && goes_after(cell_ff[k], cell_ff[k+1]);
      end else begin : g_top
         assign up_cell[k] = cell_ff[k];
         assign sw[k] = 1'b0;
      end
      if (k > 0) begin : g_dn
         assign dn_cell[k] = cell_ff[k-1];
         assign dn_sw[k]   = sw[k-1];
      end else begin : g_bot
         assign dn_cell[k] = cell_ff[k];
         assign dn_sw[k]   = 1'b0;
      end
      assign match[k] = (CW'(k) < count_ff) && (cell_ff[k].key == req_ff.item_key);

      always_comb begin
         cell_in[k] = cell_ff[k];
         if (cmd.append && count_ff == CW'(k)) begin
            cell_in[k].key  = req_ff.item_key;
            cell_in[k].prio = req_ff.item_priority;
            cell_in[k].len  = req_ff.item_len;
            cell_in[k].ev   = req_ff.item_event_ready;
         end
         if (cmd.sort_pass) begin
            if (sw[k]) cell_in[k] = up_cell[k];
            else if (dn_sw[k]) cell_in[k] = dn_cell[k];
         end
         if (cmd.remove && CW'(k) >= CW'(scan_ff) && CW'(k + 1) < count_ff) begin
            cell_in[k] = up_cell[k];
         end
         if (cmd.set_event && match[k]) begin
            cell_in[k].ev = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   // request beat, scan and pass counters
   always_ff @(posedge clock) begin
      if (cmd.latch) req_ff <= req_payload;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append) count_in = count_ff + CW'(1);
      else if (cmd.remove) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pass_ff  <= '0;
         scan_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.append) pass_ff <= '0;
         else if (cmd.sort_pass) pass_ff <= pass_ff + CW'(1);
         if (cmd.scan_reset) scan_ff <= '0;
         else if (cmd.scan_next) scan_ff <= scan_ff + QW'(1);
         if (cmd.clear_step) clr_ff <= clr_ff + KW'(1);
      end
   end

   // key ready memory, cleared by a sweep after reset
   assign scan_cell    = cell_ff[scan_ff];
   assign req_key_ext  = 32'(req_ff.item_key);
   assign cell_key_ext = 32'(scan_cell.key);
   assign q_key_ext    = 32'(scan_q_ff.key);
   assign req_inrange  = req_key_ext < 32'(KEY_SPACE);
   assign cell_inrange = cell_key_ext < 32'(KEY_SPACE);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = 1'b0;
      if (cmd.clear_step) begin
         mem_we = 1'b1;
      end else if (cmd.set_mark) begin
         mem_we    = req_inrange;
         mem_waddr = req_key_ext[KW-1:0];
         mem_wdata = 1'b1;
      end else if (cmd.clear_mark) begin
         mem_we    = inrange_ff;
         mem_waddr = q_key_ext[KW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mark_mem[mem_waddr] <= mem_wdata;
      if (cmd.scan_load) mark_ff <= mark_mem[cell_key_ext[KW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_load) begin
         scan_q_ff  <= scan_cell;
         inrange_ff <= cell_inrange;
      end
   end

   // credit counter
   assign refund_sum = {1'b0, credit_ff} + 37'(req_ff.item_len);

   always_comb begin
      credit_in = credit_ff;
      if (cfg.credit_load) credit_in = cfg.credit_val;
      else if (cmd.charge) credit_in = credit_ff - 36'(scan_q_ff.len);
      else if (cmd.refund) credit_in = refund_sum[36] ? CREDIT_MAX : refund_sum[35:0];
   end

   always_ff @(posedge clock) begin
      if (reset) credit_ff <= CREDIT_RESET;
      else credit_ff <= credit_in;
   end

   // status to the sequencer
   always_comb begin
      stat.full       = (count_ff == CW'(QUEUE_DEPTH));
      stat.empty      = (count_ff == '0);
      stat.sort_last  = (pass_ff + CW'(1) >= count_ff);
      stat.scan_last  = (CW'(scan_ff) + CW'(1) == count_ff);
      stat.evt_any    = |match;
      stat.clear_last = (clr_ff == KW'(KEY_SPACE - 1));
      if (req_ff.mode == MODE_GET_NEXT) begin
         stat.hit = scan_q_ff.ev
                    && (!cfg.sched || {4'b0, scan_q_ff.len} <= credit_ff)
                    && (!cfg.gate || (inrange_ff && mark_ff));
      end else begin
         stat.hit = (scan_q_ff.key == req_ff.item_key);
      end
   end

   // result register
   assign count_ext = 32'(count_in);

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ff.status        <= cmd.status;
         rsp_ff.out_key       <= cmd.removed ? scan_q_ff.key : '0;
         rsp_ff.out_priority  <= cmd.removed ? scan_q_ff.prio : '0;
         rsp_ff.out_len       <= cmd.removed ? scan_q_ff.len : '0;
         rsp_ff.pending_count <= count_ext[6:0];
         rsp_ff.credits_left  <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.respond;
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/credit_priority_task_queue.sv
`timescale 1ns / 1ps
// credit_priority_task_queue: top level with register port, sequencer and datapath
// depends on cptq_pkg, cptq_ctrl and cptq_dp
//
// A command beat is taken when start is high and busy is low; each command gives
// exactly one result, shown on rsp_payload for one cycle with rsp_strobe high,
// and the receiver cannot stall it. After reset the key ready memory is swept,
// one entry a cycle, and busy stays high until the sweep is done. Add, finish, event
// ready and key ready are latched, pass the execute state, then the result register.
// A scheduled add then runs one odd-even compare pass per held task. Get next and
// get by key walk the store from the head, one entry at a time (the cell and its
// key ready bit are read together, then the eligibility check is made).
module credit_priority_task_queue
   import cptq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64,
   parameter int KEY_SPACE   = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic        sched_ff;
   logic [35:0] credit_init_ff;
   logic        gate_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;
   cfg_type     cfg;
   cmd_type     cmd;
   stat_type    stat;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         sched_ff       <= 1'b0;
         credit_init_ff <= CREDIT_RESET;
         gate_ff        <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SCHED:    sched_ff       <= csr_pwdata[0];
            CSR_CREDIT:   credit_init_ff <= csr_pwdata[35:0];
            CSR_KEY_GATE: gate_ff        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SCHED:    csr_prdata = {63'b0, sched_ff};
         CSR_CREDIT:   csr_prdata = {28'b0, credit_init_ff};
         CSR_KEY_GATE: csr_prdata = {63'b0, gate_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // configuration seen by the datapath
   assign cfg.sched       = sched_ff;
   assign cfg.gate        = gate_ff;
   assign cfg.credit_load = csr_wr && (csr_idx == CSR_CREDIT);
   assign cfg.credit_val  = csr_pwdata[35:0];

   cptq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_payload.mode),
      .sched    (sched_ff),
      .gate     (gate_ff),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   cptq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KEY_SPACE   (KEY_SPACE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_payload (req_payload),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

### verif/credit_priority_task_queue_tb.sv
`timescale 1ns / 1ps
// credit_priority_task_queue_tb: self-checking bench for the credit priority task queue
// depends on cptq_pkg and credit_priority_task_queue; predicts every result beat
module credit_priority_task_queue_tb;
   import cptq_pkg::*;

   localparam int DEPTH      = 64;
   localparam int WATCH_MAX  = 20000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   credit_priority_task_queue dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // queue shadow state
   logic [9:0]         sh_key  [DEPTH];
   logic signed [15:0] sh_prio [DEPTH];
   logic [31:0]        sh_len  [DEPTH];
   logic               sh_ev   [DEPTH];
   int                 sh_count;
   logic [35:0]        sh_credit;
   logic [1023:0]      sh_marks;
   logic               sh_sched;
   logic               sh_gate;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      sender_idle_pct;
   int      error_count;
   int      quiet_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      error_count++;
   endtask

   function automatic logic ranks_after(int a, int b);
      if (sh_prio[a] != sh_prio[b]) return sh_prio[a] < sh_prio[b];
      return sh_key[a] > sh_key[b];
   endfunction

   function automatic void drop_entry(int idx);
      for (int j = idx; j + 1 < sh_count; j++) begin
         sh_key[j]  = sh_key[j+1];
         sh_prio[j] = sh_prio[j+1];
         sh_len[j]  = sh_len[j+1];
         sh_ev[j]   = sh_ev[j+1];
      end
      sh_count--;
   endfunction

   // expected result of one accepted command beat
   function automatic rsp_type predict_task_queue(req_type c);
      rsp_type            r;
      logic [9:0]         tk;
      logic signed [15:0] tp;
      logic [31:0]        tl;
      logic               te;
      logic [36:0]        sum;
      int                 hit;
      r = '0;
      r.status = STAT_OK;
      hit = -1;
      case (c.mode)
         MODE_ADD: begin
            if (sh_count >= DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               sh_key[sh_count]  = c.item_key;
               sh_prio[sh_count] = c.item_priority;
               sh_len[sh_count]  = c.item_len;
               sh_ev[sh_count]   = c.item_event_ready;
               sh_count++;
               // stable insertion sort over the whole store
               if (sh_sched) begin
                  for (int i = 1; i < sh_count; i++)
                     for (int j = i; j > 0 && ranks_after(j - 1, j); j--) begin
                        tk = sh_key[j-1];  sh_key[j-1]  = sh_key[j];  sh_key[j]  = tk;
                        tp = sh_prio[j-1]; sh_prio[j-1] = sh_prio[j]; sh_prio[j] = tp;
                        tl = sh_len[j-1];  sh_len[j-1]  = sh_len[j];  sh_len[j]  = tl;
                        te = sh_ev[j-1];   sh_ev[j-1]   = sh_ev[j];   sh_ev[j]   = te;
                     end
               end
            end
         end
         MODE_GET_NEXT: begin
            for (int i = 0; i < sh_count && hit < 0; i++) begin
               if (sh_ev[i] && !(sh_sched && {4'd0, sh_len[i]} > sh_credit)) begin
                  if (!sh_gate) begin
                     hit = i;
                  end else if (sh_marks[sh_key[i]]) begin
                     sh_marks[sh_key[i]] = 1'b0;
                     hit = i;
                  end
               end
            end
            if (hit < 0) begin
               r.status = STAT_NONE;
            end else begin
               r.out_key = sh_key[hit];
               r.out_priority = sh_prio[hit];
               r.out_len = sh_len[hit];
               if (sh_sched) sh_credit = sh_credit - {4'd0, sh_len[hit]};
               drop_entry(hit);
            end
         end
         MODE_GET_KEY: begin
            if (sh_sched) begin
               r.status = STAT_REFUSED;
            end else begin
               for (int i = 0; i < sh_count && hit < 0; i++)
                  if (sh_key[i] == c.item_key) hit = i;
               if (hit < 0) begin
                  r.status = STAT_NONE;
               end else begin
                  r.out_key = sh_key[hit];
                  r.out_priority = sh_prio[hit];
                  r.out_len = sh_len[hit];
                  drop_entry(hit);
               end
            end
         end
         MODE_FINISH: begin
            if (sh_sched) begin
               sum = {1'b0, sh_credit} + {5'd0, c.item_len};
               sh_credit = sum[36] ? CREDIT_MAX : sum[35:0];
            end
         end
         MODE_EVENT_RDY: begin
            for (int i = 0; i < sh_count; i++)
               if (sh_key[i] == c.item_key) begin
                  sh_ev[i] = 1'b1;
                  hit = i;
               end
            if (hit < 0) r.status = STAT_NONE;
         end
         MODE_KEY_RDY: sh_marks[c.item_key] = 1'b1;
         default: ;
      endcase
      r.pending_count = sh_count[6:0];
      r.credits_left = sh_credit;
      return r;
   endfunction

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_payload <= '0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_rsps = {expected_rsps, predict_task_queue(pending_cmds[0])};
            void'(pending_cmds.pop_front());
         end
         if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            start <= 1'b1;
            req_payload <= pending_cmds[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result beat", 64'(rsp_payload.status), 64'd0);
         end else begin
            if (rsp_payload.status !== expected_rsps[0].status)
               report_mismatch("status", 64'(rsp_payload.status),
                               64'(expected_rsps[0].status));
            if (rsp_payload.out_key !== expected_rsps[0].out_key)
               report_mismatch("out_key", 64'(rsp_payload.out_key),
                               64'(expected_rsps[0].out_key));
            if (rsp_payload.out_priority !== expected_rsps[0].out_priority)
               report_mismatch("out_priority", 64'(rsp_payload.out_priority),
                               64'(expected_rsps[0].out_priority));
            if (rsp_payload.out_len !== expected_rsps[0].out_len)
               report_mismatch("out_len", 64'(rsp_payload.out_len),
                               64'(expected_rsps[0].out_len));
            if (rsp_payload.pending_count !== expected_rsps[0].pending_count)
               report_mismatch("pending_count", 64'(rsp_payload.pending_count),
                               64'(expected_rsps[0].pending_count));
            if (rsp_payload.credits_left !== expected_rsps[0].credits_left)
               report_mismatch("credits_left", 64'(rsp_payload.credits_left),
                               64'(expected_rsps[0].credits_left));
            void'(expected_rsps.pop_front());
         end
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_MAX) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         CSR_SCHED:    sh_sched = value[0];
         CSR_CREDIT:   sh_credit = value[35:0];
         CSR_KEY_GATE: sh_gate = value[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_cmd(logic [2:0] m, logic [9:0] k, logic signed [15:0] p,
                           logic [31:0] l, logic e);
      req_type c;
      c.mode = m;
      c.item_key = k;
      c.item_priority = p;
      c.item_len = l;
      c.item_event_ready = e;
      pending_cmds = {pending_cmds, c};
   endtask

   // random command mix, mostly a small key and priority pool so matches happen
   task automatic push_random(int add_pct, logic [31:0] len_cap);
      logic [2:0]  m;
      logic [9:0]  k;
      logic [15:0] p;
      logic [31:0] l;
      int          r;
      r = $urandom_range(99);
      if (r < add_pct) m = MODE_ADD;
      else if (r < 98) m = 3'($urandom_range(MODE_GET_NEXT, MODE_KEY_RDY));
      else m = 3'($urandom_range(6, 7));
      k = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(7));
      p = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      // length bound taken in 33 bits so a full-range cap does not wrap to zero
      l = ($urandom_range(9) == 0) ? $urandom
          : 32'({1'b0, $urandom} % ({1'b0, len_cap} + 33'd1));
      push_cmd(m, k, p, l, 1'($urandom));
   endtask

   task automatic run_phase(logic sched, logic [35:0] credit, logic gate, int idle,
                            int add_pct, logic [31:0] len_cap, int count);
      wait_drained();
      write_reg(CSR_SCHED, {63'd0, sched});
      write_reg(CSR_CREDIT, {28'd0, credit});
      write_reg(CSR_KEY_GATE, {63'd0, gate});
      sender_idle_pct = idle;
      for (int i = 0; i < count / 2; i++) push_random(add_pct, len_cap);
      // hold the sender until the queue has answered everything
      wait_drained();
      for (int i = count / 2; i < count; i++) push_random(add_pct, len_cap);
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      sender_idle_pct = 0;
      sh_count = 0;
      sh_credit = CREDIT_RESET;
      sh_marks = '0;
      sh_sched = 1'b0;
      sh_gate = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset defaults, arrival order
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_ADD, 10'd1023, 16'h7fff, 32'hffff_ffff, 1'b1);
      push_cmd(MODE_ADD, 10'd0, 16'h8000, 32'd0, 1'b0);
      push_cmd(MODE_ADD, 10'd5, 16'sd3, 32'd100, 1'b1);
      push_cmd(MODE_GET_KEY, 10'd0, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_GET_KEY, 10'd77, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_EVENT_RDY, 10'd99, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_FINISH, 10'd0, 16'sd0, 32'hffff_ffff, 1'b0);
      push_cmd(3'd6, 10'h2aa, 16'h5555, 32'haaaa_aaaa, 1'b1);
      push_cmd(3'd7, 10'h155, 16'haaaa, 32'h5555_5555, 1'b0);
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);
      wait_drained();

      // directed: scheduled reorder, credits, key gating
      write_reg(CSR_SCHED, 64'd1);
      write_reg(CSR_CREDIT, 64'd150);
      write_reg(CSR_KEY_GATE, 64'd1);
      push_cmd(MODE_ADD, 10'd4, 16'sd2, 32'd200, 1'b1);
      push_cmd(MODE_ADD, 10'd3, 16'sd2, 32'd50, 1'b0);
      push_cmd(MODE_GET_KEY, 10'd3, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_EVENT_RDY, 10'd3, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_KEY_RDY, 10'd3, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_KEY_RDY, 10'd1023, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);
      push_cmd(MODE_FINISH, 10'd0, 16'sd0, 32'd1000, 1'b0);
      push_cmd(MODE_GET_NEXT, 10'd0, 16'sd0, 32'd0, 1'b0);

      // random phases across the settings and idle rates
      run_phase(1'b0, CREDIT_RESET, 1'b0, 0, 45, 32'd1000, 150);
      run_phase(1'b1, 36'd0, 1'b0, 67, 40, 32'd20, 150);
      run_phase(1'b1, CREDIT_MAX, 1'b0, 0, 40, 32'hffff_ffff, 150);
      run_phase(1'b0, 36'($urandom), 1'b1, 15, 40, 32'd1000, 150);
      run_phase(1'b1, 36'd5000, 1'b1, 67, 40, 32'd800, 150);
      run_phase(1'b0, CREDIT_MAX, 1'b0, 0, 75, 32'd100, 150);
      run_phase(1'b1, 36'd3000, 1'b0, 15, 75, 32'd500, 150);
      run_phase(1'b0, 36'd0, 1'b1, 0, 40, 32'd100, 100);

      wait_drained();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
